// File: sv/opat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opat_pkg
// Shared types, sizes and codes for the one-shot/periodic alarm table.
// ----------------------------------------------------------------------------
package opat_pkg;

  localparam int unsigned OS_SLOTS  = 16;
  localparam int unsigned PER_SLOTS = 8;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned OS_IDX_W  = (OS_SLOTS > 1) ? $clog2(OS_SLOTS) : 1;
  localparam int unsigned PER_IDX_W = (PER_SLOTS > 1) ? $clog2(PER_SLOTS) : 1;
  localparam int unsigned SCAN_W    = $clog2(OS_SLOTS + PER_SLOTS + 1);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Request codes
  localparam logic [2:0] REQ_ADD_OS   = 3'd0;
  localparam logic [2:0] REQ_ADD_PER  = 3'd1;
  localparam logic [2:0] REQ_DROP_OS  = 3'd2;
  localparam logic [2:0] REQ_DROP_PER = 3'd3;
  localparam logic [2:0] REQ_EXEC     = 3'd4;
  localparam logic [2:0] REQ_QUERY    = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  handler_id;
    logic [15:0] param_id;
    logic        param_present;
    logic [23:0] duration_ms;
    logic        keep_existing;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        fired_valid;
    logic        fired_periodic;
    logic [7:0]  fired_handler;
    logic [15:0] fired_param;
    logic        fired_has_param;
    logic [47:0] next_due_ms;
    logic        last;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;     // capture request
    logic              step;     // process current slot, advance
    logic              do_add;   // write new entry into free slot
    logic              emit;     // write output register
    logic              emit_none;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic hit;        // current slot produces a fired result
    logic out_busy;   // output register holds a stalled transaction
  } sts_t;

  // Saturating add clipped to TIME_W bits
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/oneshot_periodic_alarm_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oneshot_periodic_alarm_table_top
// Table of one-shot and periodic alarms with add, drop, execute and query.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i/in_stall_o/in_data_i; a transaction
//   completes when in_valid_i is high and in_stall_o low. Results leave on
//   out_valid_o/out_stall_i/out_data_o the same way, and the last result of
//   a request has last set.
//   Each request walks all 24 slots (16 one-shot, then 8 periodic), one slot
//   per cycle unless a firing slot waits on a stalled output, and then
//   writes its final result. The block takes one request at a time;
//   in_stall_o stays high until the final result is in the output register.
//   An execute emits one result per expired slot, each one released when the
//   next slot fires or the scan ends; while out_stall_i holds the output
//   register, the scan waits at a firing slot.
//   Reset clears all valid bits, the output valid among them; table contents
//   and output data are left as they are.
// ----------------------------------------------------------------------------
module oneshot_periodic_alarm_table_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire opat_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output opat_pkg::rsp_t      out_data_o
);

  opat_pkg::cmd_t cmd;
  opat_pkg::sts_t sts;

  opat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  opat_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// File: sv/opat_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opat_ctrl
// Sequencer: accept a request, step the slot scan, emit results.
// ----------------------------------------------------------------------------
module opat_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire opat_pkg::sts_t sts_i,
  output opat_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       fired_q, fired_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    fired_d = fired_q;
    cmd_o   = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          fired_d    = 1'b0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // A hit needs the output register free before advancing
        if (sts_i.scan_done) begin
          state_d = ST_FIN;
        end else if (!(sts_i.hit && sts_i.out_busy)) begin
          cmd_o.step = 1'b1;
          if (sts_i.hit) begin
            // Release the previous fired result; the newest one waits
            cmd_o.emit = fired_q;
            fired_d    = 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.do_add    = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_none = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fired_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fired_q <= fired_d;
    end
  end

  // Final emit always comes from the finish state
  a_fin_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_none |-> (state_q == ST_FIN))
    else $error("final emit outside finish state");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_SCAN))
    else $error("load did not start scan");
  a_no_step_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !cmd_o.step)
    else $error("step during finish");

endmodule
`default_nettype wire

// File: sv/opat_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opat_dp
// Alarm tables, request registers, slot scan and output register.
// ----------------------------------------------------------------------------
module opat_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire opat_pkg::req_t req_i,
  input  wire opat_pkg::cmd_t cmd_i,
  output opat_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output opat_pkg::rsp_t      out_data_o
);

  localparam int unsigned NOS  = opat_pkg::OS_SLOTS;
  localparam int unsigned NPER = opat_pkg::PER_SLOTS;
  localparam int unsigned TW   = opat_pkg::TIME_W;
  localparam int unsigned SW   = opat_pkg::SCAN_W;

  // Tables
  logic [NOS-1:0]  os_vld_q;
  logic [TW-1:0]   os_due_q   [NOS];
  logic [7:0]      os_hid_q   [NOS];
  logic [15:0]     os_par_q   [NOS];
  logic            os_pf_q    [NOS];
  logic [NPER-1:0] per_vld_q;
  logic [TW-1:0]   per_due_q  [NPER];
  logic [23:0]     per_int_q  [NPER];
  logic [7:0]      per_hid_q  [NPER];

  opat_pkg::req_t  req_q;
  logic [SW-1:0]   idx_q;
  logic [TW-1:0]   best_q;
  logic            fired_q;
  logic            out_valid_q;
  opat_pkg::rsp_t  out_q;
  opat_pkg::rsp_t  pend_q;    // newest fired result, held until the next one or the end
  opat_pkg::rsp_t  hit_rsp, fin_rsp;

  logic            in_os, in_per;
  logic [opat_pkg::OS_IDX_W-1:0]  oi;
  logic [opat_pkg::PER_IDX_W-1:0] pi;
  logic            os_match, per_match, os_hit, per_hit;
  logic [TW-1:0]   cur_due;
  logic            cur_vld;
  logic [TW-1:0]   per_adv, per_next;
  logic [TW-1:0]   now_t;
  logic            is_os_req, is_per_req;
  logic            os_full, per_full;
  logic [opat_pkg::OS_IDX_W-1:0]  os_free;
  logic [opat_pkg::PER_IDX_W-1:0] per_free;

  assign now_t = req_q.now_ms[TW-1:0];
  assign in_os  = (idx_q < SW'(NOS));
  assign in_per = !in_os && (idx_q < SW'(NOS + NPER));
  assign oi = idx_q[opat_pkg::OS_IDX_W-1:0];
  assign pi = opat_pkg::PER_IDX_W'(idx_q - SW'(NOS));

  assign is_os_req  = (req_q.req_type == opat_pkg::REQ_ADD_OS) ||
                      (req_q.req_type == opat_pkg::REQ_DROP_OS);
  assign is_per_req = (req_q.req_type == opat_pkg::REQ_ADD_PER) ||
                      (req_q.req_type == opat_pkg::REQ_DROP_PER);

  // Per-slot evaluation of the current scan position
  always_comb begin
    os_match = in_os && is_os_req && os_vld_q[oi] &&
               (os_hid_q[oi] == req_q.handler_id) &&
               (!req_q.param_present ||
                (os_pf_q[oi] && os_par_q[oi] == req_q.param_id)) &&
               ((req_q.req_type == opat_pkg::REQ_DROP_OS) ||
                (req_q.param_present && !req_q.keep_existing));
    per_match = in_per && per_vld_q[pi] && (per_hid_q[pi] == req_q.handler_id);
    os_hit  = in_os && os_vld_q[oi] && (os_due_q[oi] <= now_t);
    per_hit = in_per && per_vld_q[pi] && (per_due_q[pi] <= now_t);
    cur_due = in_os ? os_due_q[oi] : per_due_q[pi];
    cur_vld = in_os ? os_vld_q[oi] : (in_per && per_vld_q[pi]);
    per_adv  = opat_pkg::sat_add(per_due_q[pi], TW'(per_int_q[pi]));
    per_next = (per_adv <= now_t) ? opat_pkg::sat_add(now_t, TW'(1)) : per_adv;
  end

  // Lowest free slot after removals
  always_comb begin
    os_free  = '0;
    per_free = '0;
    for (int i = NOS - 1; i >= 0; i--)
      if (!os_vld_q[i]) os_free = opat_pkg::OS_IDX_W'(i);
    for (int i = NPER - 1; i >= 0; i--)
      if (!per_vld_q[i]) per_free = opat_pkg::PER_IDX_W'(i);
  end
  assign os_full  = &os_vld_q;
  assign per_full = &per_vld_q;

  // Build the fired result and the final result of a request
  always_comb begin
    hit_rsp                 = '0;
    hit_rsp.fired_valid     = 1'b1;
    hit_rsp.fired_periodic  = in_per;
    hit_rsp.fired_handler   = in_os ? os_hid_q[oi] : per_hid_q[pi];
    hit_rsp.fired_param     = in_os ? os_par_q[oi] : 16'd0;
    hit_rsp.fired_has_param = in_os ? os_pf_q[oi] : 1'b0;
    fin_rsp = '0;
    if (fired_q) begin
      fin_rsp = pend_q;
    end else begin
      fin_rsp.status = ((req_q.req_type == opat_pkg::REQ_ADD_OS) && os_full) ||
                       ((req_q.req_type == opat_pkg::REQ_ADD_PER) && per_full);
      if (req_q.req_type == opat_pkg::REQ_QUERY) fin_rsp.next_due_ms = best_q;
    end
    fin_rsp.last = 1'b1;
  end

  assign sts_o.scan_done = (idx_q == SW'(NOS + NPER));
  assign sts_o.hit       = (req_q.req_type == opat_pkg::REQ_EXEC) && (os_hit || per_hit);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      os_vld_q    <= '0;
      per_vld_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      fired_q     <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit || (out_valid_q && out_stall_i);
      if (cmd_i.load) begin
        idx_q   <= '0;
        fired_q <= 1'b0;
      end
      if (cmd_i.step) begin
        idx_q <= idx_q + SW'(1);
        if (sts_o.hit) fired_q <= 1'b1;
        if (in_os && (os_match ||
            (req_q.req_type == opat_pkg::REQ_EXEC && os_hit)))
          os_vld_q[oi] <= 1'b0;
        if (is_per_req && per_match) per_vld_q[pi] <= 1'b0;
      end
      if (cmd_i.do_add) begin
        if (req_q.req_type == opat_pkg::REQ_ADD_OS && !os_full)
          os_vld_q[os_free] <= 1'b1;
        if (req_q.req_type == opat_pkg::REQ_ADD_PER && !per_full)
          per_vld_q[per_free] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_i;
      best_q <= opat_pkg::TIME_MAX;
    end
    if (cmd_i.step) begin
      if (cur_vld && cur_due < best_q) best_q <= cur_due;
      if (req_q.req_type == opat_pkg::REQ_EXEC && per_hit) per_due_q[pi] <= per_next;
      if (sts_o.hit) pend_q <= hit_rsp;
    end
    if (cmd_i.do_add) begin
      if (req_q.req_type == opat_pkg::REQ_ADD_OS && !os_full) begin
        os_due_q[os_free] <= opat_pkg::sat_add(now_t, TW'(req_q.duration_ms));
        os_hid_q[os_free] <= req_q.handler_id;
        os_par_q[os_free] <= req_q.param_present ? req_q.param_id : 16'd0;
        os_pf_q[os_free]  <= req_q.param_present;
      end
      if (req_q.req_type == opat_pkg::REQ_ADD_PER && !per_full) begin
        per_due_q[per_free] <= opat_pkg::sat_add(now_t, TW'(req_q.duration_ms));
        per_int_q[per_free] <= req_q.duration_ms;
        per_hid_q[per_free] <= req_q.handler_id;
      end
    end
    // Output transaction
    if (cmd_i.emit) out_q <= cmd_i.emit_none ? fin_rsp : pend_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.emit)
    else $error("output overwritten while stalled");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= SW'(NOS + NPER))
    else $error("scan index out of range");
  a_step_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !cmd_i.load) |=> (idx_q == $past(idx_q) + SW'(1)))
    else $error("scan did not advance");

endmodule
`default_nettype wire
